### hw/rtl/ilt_pkg.sv
// Shared types and constants for the INI line tokenizer.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package ilt_pkg;

    localparam int DEFAULT_STRING_CAPACITY = 255;

    localparam logic OP_FEED = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [1:0] SEL_SECTION = 2'd0;
    localparam logic [1:0] SEL_KEY     = 2'd1;
    localparam logic [1:0] SEL_VALUE   = 2'd2;

    localparam logic [7:0] CH_SEMI       = 8'h3B;
    localparam logic [7:0] CH_LBRACK     = 8'h5B;
    localparam logic [7:0] CH_RBRACK     = 8'h5D;
    localparam logic [7:0] CH_EQUAL      = 8'h3D;
    localparam logic [7:0] CH_NEWLINE    = 8'h0A;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_DEL        = 8'h7F;
    localparam logic [7:0] CH_CTRL_LIMIT = 8'h20;

    typedef enum logic [2:0] {
        PH_BLANK,
        PH_COMMENT,
        PH_SECTION,
        PH_KEY,
        PH_AFTER_KEY,
        PH_BEFORE_VALUE,
        PH_VALUE,
        PH_INVALID
    } t_phase;

    typedef enum logic [1:0] {
        CM_NONE,
        CM_SECTION,
        CM_KEY,
        CM_VALUE
    } t_commit;

    typedef logic [1:0] t_bank;

    typedef struct packed {
        logic       op;
        logic [7:0] text_byte;
        logic [1:0] string_select;
        logic [7:0] char_index;
    } t_in;

    typedef struct packed {
        logic       record_ready;
        logic [7:0] section_length;
        logic [7:0] key_length;
        logic [7:0] value_length;
        logic [7:0] read_char;
        logic       overflow;
    } t_out;

    typedef struct packed {
        logic       record_ready;
        logic       overflow;
        logic       rd_hit;
        logic [7:0] section_length;
        logic [7:0] key_length;
        logic [7:0] value_length;
    } t_ctl;

endpackage

### hw/rtl/ilt_if.sv
// Valid/ready channel interfaces for the tokenizer requests and results.
// Depends on ilt_pkg.
`timescale 1ns / 1ps

interface ilt_in_if;
    logic         valid;
    logic         ready;
    ilt_pkg::t_in data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

interface ilt_out_if;
    logic          valid;
    logic          ready;
    ilt_pkg::t_out data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

### hw/rtl/ini_line_tokenizer_unit.sv
// INI line tokenizer top level: request/result channels and string RAM.
// Depends on ilt_pkg, ilt_if, ilt_ram and ilt_parser.
`timescale 1ns / 1ps

// Takes one request per clock cycle, sustained, under any output stall pattern
// that leaves the result channel free. A text byte (op 0) updates the parse
// phase and writes at most one byte into the string RAM; a read (op 1) reads
// one byte back. Each result passes through the registered RAM read, held in step
// with the request's registered control, and then the output register. All four
// strings (section, key, value and the working buffer) live as banks of a
// single one-write, one-read RAM of 4 x 2**ceil(log2(STRING_CAPACITY)) bytes;
// committing a string renames banks instead of copying, so a commit never holds
// up the request channel. The RAM needs no clearing after reset.

module ini_line_tokenizer_unit #(
    parameter int STRING_CAPACITY = ilt_pkg::DEFAULT_STRING_CAPACITY
) (
    input logic      i_clk,
    input logic      i_rst_n,
    ilt_in_if.sink   i_in,
    ilt_out_if.source o_out
);

    import ilt_pkg::*;

    localparam int AW    = $clog2(STRING_CAPACITY);
    localparam int DEPTH = 1 << (AW + 2);

    logic          in_fire;
    logic          out_free;
    logic          s1_move;
    logic          wr_en, rd_en;
    logic [AW+1:0] wr_addr, rd_addr;
    logic [7:0]    wr_data, rd_data;
    t_ctl          ctl;

    logic          r_s1_valid;
    t_ctl          r_s1_ctl;
    logic          r_o_valid;
    t_out          r_o_data;

    assign out_free   = !r_o_valid || o_out.ready;
    assign s1_move    = r_s1_valid && out_free;
    assign i_in.ready = !r_s1_valid || out_free;
    assign in_fire    = i_in.valid && i_in.ready;

    ilt_parser #(
        .STRING_CAPACITY(STRING_CAPACITY)
    ) u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (in_fire),
        .i_req     (i_in.data),
        .o_wr_en   (wr_en),
        .o_wr_addr (wr_addr),
        .o_wr_data (wr_data),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .o_ctl     (ctl)
    );

    ilt_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_ctl <= ctl;
        end
        if (s1_move) begin
            r_o_data.record_ready   <= r_s1_ctl.record_ready;
            r_o_data.section_length <= r_s1_ctl.section_length;
            r_o_data.key_length     <= r_s1_ctl.key_length;
            r_o_data.value_length   <= r_s1_ctl.value_length;
            r_o_data.read_char      <= r_s1_ctl.rd_hit ? rd_data : 8'h00;
            r_o_data.overflow       <= r_s1_ctl.overflow;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.data  = r_o_data;

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> (r_s1_valid && $stable(r_s1_ctl)))
        else $error("stalled request lost");

    a_record_no_ovf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_data.record_ready) |-> !r_o_data.overflow)
        else $error("record and overflow on one byte");

endmodule

### hw/rtl/ilt_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ilt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/ilt_parser.sv
// Parse-phase state machine, string lengths and bank map over the string RAM.
// Depends on ilt_pkg; drives the ports of one ilt_ram.
`timescale 1ns / 1ps

module ilt_parser #(
    parameter int STRING_CAPACITY = ilt_pkg::DEFAULT_STRING_CAPACITY,
    localparam int AW = $clog2(STRING_CAPACITY)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_fire,
    input  ilt_pkg::t_in  i_req,
    output logic          o_wr_en,
    output logic [AW+1:0] o_wr_addr,
    output logic [7:0]    o_wr_data,
    output logic          o_rd_en,
    output logic [AW+1:0] o_rd_addr,
    output ilt_pkg::t_ctl o_ctl
);

    import ilt_pkg::*;

    localparam int LW  = $clog2(STRING_CAPACITY + 1);
    localparam int CW  = (LW > 8) ? LW : 8;
    localparam int IW  = (AW > 8) ? AW : 8;
    localparam logic [LW-1:0] CAP = LW'(STRING_CAPACITY);

    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_wlen, n_wlen;
    logic [LW-1:0] r_wtrim, n_wtrim;
    logic [LW-1:0] r_slen, n_slen;
    logic [LW-1:0] r_klen, n_klen;
    logic [LW-1:0] r_vlen, n_vlen;
    t_bank         r_map_sec, r_map_key, r_map_val, r_map_work;
    t_bank         n_map_sec, n_map_key, n_map_val, n_map_work;

    logic          feed;
    logic [7:0]    b;
    logic          is_ctrl, is_blank, is_nl;
    logic          act_append, act_clear;
    t_commit       act_commit;
    logic          has_room;
    logic          store_byte;
    logic [LW-1:0] wlen_inc;
    logic [CW-1:0] sl_w, kl_w, vl_w;
    logic [IW-1:0] idx_w;
    logic [LW-1:0] sel_len;
    t_bank         sel_bank;
    logic          sel_ok;

    assign feed     = i_fire && (i_req.op == OP_FEED);
    assign b        = i_req.text_byte;
    assign is_ctrl  = (b < CH_CTRL_LIMIT) || (b == CH_DEL);
    assign is_blank = (b == CH_SPACE) || (b == CH_TAB);
    assign is_nl    = (b == CH_NEWLINE);
    assign has_room = r_wlen < CAP;
    assign wlen_inc = r_wlen + LW'(1);

    // per-phase actions on the working buffer
    always_comb begin
        act_append = 1'b0;
        act_clear  = 1'b0;
        act_commit = CM_NONE;
        unique case (r_phase)
            PH_BLANK: begin
                act_append = !(b == CH_SEMI || b == CH_LBRACK || is_blank || is_nl);
            end
            PH_SECTION: begin
                if (b == CH_RBRACK) begin
                    act_commit = CM_SECTION;
                    act_clear  = 1'b1;
                end else if (is_nl) begin
                    act_clear = 1'b1;
                end else begin
                    act_append = 1'b1;
                end
            end
            PH_KEY: begin
                if (is_blank) begin
                    act_commit = CM_KEY;
                    act_clear  = 1'b1;
                end else if (is_nl) begin
                    act_clear = 1'b1;
                end else begin
                    act_append = 1'b1;
                end
            end
            PH_BEFORE_VALUE: begin
                act_append = !(is_nl || is_blank);
            end
            PH_VALUE: begin
                if (is_nl) begin
                    act_commit = CM_VALUE;
                    act_clear  = 1'b1;
                end else begin
                    act_append = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (feed) begin
            unique case (r_phase)
                PH_BLANK: begin
                    if (b == CH_SEMI) begin
                        n_phase = PH_COMMENT;
                    end else if (b == CH_LBRACK) begin
                        n_phase = PH_SECTION;
                    end else if (!(is_blank || is_nl)) begin
                        n_phase = PH_KEY;
                    end
                end
                PH_SECTION, PH_COMMENT, PH_VALUE, PH_INVALID: begin
                    if (is_nl || (r_phase == PH_SECTION && b == CH_RBRACK)) begin
                        n_phase = PH_BLANK;
                    end
                end
                PH_KEY: begin
                    if (is_blank) begin
                        n_phase = PH_AFTER_KEY;
                    end else if (is_nl) begin
                        n_phase = PH_BLANK;
                    end
                end
                PH_AFTER_KEY: begin
                    if (b == CH_EQUAL) begin
                        n_phase = PH_BEFORE_VALUE;
                    end else if (is_nl) begin
                        n_phase = PH_BLANK;
                    end else if (!is_blank) begin
                        n_phase = PH_INVALID;
                    end
                end
                PH_BEFORE_VALUE: begin
                    if (is_nl) begin
                        n_phase = PH_BLANK;
                    end else if (!is_blank) begin
                        n_phase = PH_VALUE;
                    end
                end
                default: begin
                    n_phase = PH_BLANK;
                end
            endcase
        end
    end

    // outputs: buffer writes, commits by bank renaming, lengths
    always_comb begin
        store_byte = feed && act_append && !is_ctrl && has_room;
        n_wlen     = r_wlen;
        n_wtrim    = r_wtrim;
        n_slen     = r_slen;
        n_klen     = r_klen;
        n_vlen     = r_vlen;
        n_map_sec  = r_map_sec;
        n_map_key  = r_map_key;
        n_map_val  = r_map_val;
        n_map_work = r_map_work;
        if (store_byte) begin
            n_wlen = wlen_inc;
            if (b != CH_SPACE) begin
                n_wtrim = wlen_inc;
            end
        end
        if (feed) begin
            case (act_commit)
                CM_SECTION: begin
                    n_slen     = r_wlen;
                    n_map_sec  = r_map_work;
                    n_map_work = r_map_sec;
                end
                CM_KEY: begin
                    n_klen     = r_wlen;
                    n_map_key  = r_map_work;
                    n_map_work = r_map_key;
                end
                CM_VALUE: begin
                    n_vlen     = r_wtrim;
                    n_map_val  = r_map_work;
                    n_map_work = r_map_val;
                end
                default: begin
                end
            endcase
            if (act_clear) begin
                n_wlen  = '0;
                n_wtrim = '0;
            end
        end
    end

    // read-back select
    always_comb begin
        sel_ok   = 1'b1;
        sel_len  = r_slen;
        sel_bank = r_map_sec;
        unique case (i_req.string_select)
            SEL_SECTION: begin
                sel_len  = r_slen;
                sel_bank = r_map_sec;
            end
            SEL_KEY: begin
                sel_len  = r_klen;
                sel_bank = r_map_key;
            end
            SEL_VALUE: begin
                sel_len  = r_vlen;
                sel_bank = r_map_val;
            end
            default: begin
                sel_ok = 1'b0;
            end
        endcase
    end

    assign idx_w = IW'(i_req.char_index);
    assign sl_w  = CW'(n_slen);
    assign kl_w  = CW'(n_klen);
    assign vl_w  = CW'(n_vlen);

    assign o_wr_en   = store_byte;
    assign o_wr_addr = {r_map_work, r_wlen[AW-1:0]};
    assign o_wr_data = b;
    assign o_rd_en   = i_fire && (i_req.op == OP_READ);
    assign o_rd_addr = {sel_bank, idx_w[AW-1:0]};

    always_comb begin
        o_ctl                = '0;
        o_ctl.record_ready   = feed && (act_commit == CM_VALUE);
        o_ctl.overflow       = feed && act_append && !is_ctrl && !has_room;
        o_ctl.rd_hit         = (i_req.op == OP_READ) && sel_ok
                               && (CW'(i_req.char_index) < CW'(sel_len));
        o_ctl.section_length = sl_w[7:0];
        o_ctl.key_length     = kl_w[7:0];
        o_ctl.value_length   = vl_w[7:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_BLANK;
            r_wlen     <= '0;
            r_wtrim    <= '0;
            r_slen     <= '0;
            r_klen     <= '0;
            r_vlen     <= '0;
            r_map_sec  <= t_bank'(0);
            r_map_key  <= t_bank'(1);
            r_map_val  <= t_bank'(2);
            r_map_work <= t_bank'(3);
        end else begin
            r_phase    <= n_phase;
            r_wlen     <= n_wlen;
            r_wtrim    <= n_wtrim;
            r_slen     <= n_slen;
            r_klen     <= n_klen;
            r_vlen     <= n_vlen;
            r_map_sec  <= n_map_sec;
            r_map_key  <= n_map_key;
            r_map_val  <= n_map_val;
            r_map_work <= n_map_work;
        end
    end

    // the four banks must stay a permutation
    a_map_perm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((4'b1 << r_map_sec) | (4'b1 << r_map_key) | (4'b1 << r_map_val)
         | (4'b1 << r_map_work)) == 4'hF)
        else $error("bank map lost a bank");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wlen <= CAP) && (r_wtrim <= r_wlen))
        else $error("working length out of range");

    a_commit_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (feed && act_commit != CM_NONE) |=> (r_phase == PH_BLANK || r_phase == PH_AFTER_KEY))
        else $error("commit left parser in wrong phase");

    a_clear_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (feed && act_clear) |=> (r_wlen == '0))
        else $error("working buffer not cleared");

endmodule
